// ===== rtl/dependency_task_dispatcher_macros.svh =====
// Assertion macros used by the dispatcher RTL
`ifndef DEPENDENCY_TASK_DISPATCHER_MACROS_SVH
`define DEPENDENCY_TASK_DISPATCHER_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define DTD_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("dispatcher check failed");

// Next-cycle implication
`define DTD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("dispatcher check failed");

`endif

// ===== rtl/dtd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dtd_pkg;
    localparam int unsigned TASKS_DEF   = 16;
    localparam int unsigned WORKERS_DEF = 4;
    localparam logic [2:0] ACT_DEF      = 3'd4;
    localparam logic [2:0] ACT_ZERO_AS  = 3'd2;

    typedef enum logic [2:0] {
        REQ_ADD   = 3'd0,
        REQ_REM   = 3'd1,
        REQ_SUB   = 3'd2,
        REQ_DONE  = 3'd3,
        REQ_QUERY = 3'd4
    } req_t;

    localparam logic [2:0] ST_INIT     = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_WAITING  = 3'd2;
    localparam logic [2:0] ST_WORKING  = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DISP = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/dependency_task_dispatcher.sv =====
// Sequence: an item taken in idle is read, then executed; after a worker finish a rescan
// visits every table entry in order and queues waiting entries whose prerequisites are complete,
// then the dispatch pass visits workers, and the acknowledge is registered before the dispatches.
// Flow: one item at a time; further results are registered whenever the output is free,
// and the next item is taken in idle once the last result is registered, unless cfg_valid is high.
// Reset: rst_n asynchronous, active low; a clearing pass over all TASKS entries runs first.
`timescale 1ns / 1ps
`default_nettype none
`include "dependency_task_dispatcher_macros.svh"
module dependency_task_dispatcher #(
    parameter int unsigned TASKS   = dtd_pkg::TASKS_DEF,
    parameter int unsigned WORKERS = dtd_pkg::WORKERS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] req_type,
    input  wire logic [3:0] task_id,
    input  wire logic [3:0] prereq_id,
    input  wire logic [1:0] worker_num,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic            ok,
    output logic [2:0]      task_status,
    output logic [3:0]      task_out,
    output logic [1:0]      worker_out,
    output logic            all_idle,
    output logic            last
);
    localparam int unsigned TW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int unsigned WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int unsigned CW = $clog2(TASKS + 1);
    localparam int unsigned BW = $clog2(WORKERS + 1);
    localparam logic [TW-1:0] TLAST = TW'(TASKS - 1);

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_RD    = 11'b00000000100,
        S_EXEC  = 11'b00000001000,
        S_SCANR = 11'b00000010000,
        S_SCANW = 11'b00000100000,
        S_DEPR  = 11'b00001000000,
        S_DEPW  = 11'b00010000000,
        S_DISP  = 11'b00100000000,
        S_DISPW = 11'b01000000000,
        S_ACK   = 11'b10000000000
    } st_t;

    // task memory: state and dependency mask per entry
    logic [2:0]       tst_mem [TASKS];
    logic [TASKS-1:0] dep_mem [TASKS];
    logic [TW-1:0]    queue_mem [2**TW];
    logic [2:0]       tst_q;
    logic [TASKS-1:0] dep_q;
    logic [TW-1:0]    qrd_q;
    logic             m_we_st, m_we_dep;
    logic [TW-1:0]    m_wa, m_ra;
    logic [2:0]       m_wst;
    logic [TASKS-1:0] m_wdep;

    // completion vector mirrors task_state == complete (needed for deps test)
    logic [TASKS-1:0] comp_reg, comp_next;
    logic [TASKS-1:0] wait_reg, wait_next;
    logic [TW-1:0]    qh_reg, qh_next, qt_reg, qt_next;
    logic [CW-1:0]    qc_reg, qc_next;
    logic [WORKERS-1:0] wbusy_reg, wbusy_next;
    logic [TW-1:0]    wtask_reg [WORKERS];
    logic [TW-1:0]    wtask_next [WORKERS];
    logic [BW-1:0]    bc_reg, bc_next;
    logic             fin_reg, fin_next;
    logic [2:0]       act_reg;
    st_t              st_reg, st_next;
    logic [TW-1:0]    idx_reg, idx_next;
    logic [WW:0]      wi_reg, wi_next;
    logic [2:0]       rq_reg;
    logic [3:0]       tid_reg, pid_reg, ackt_reg, ackt_next;
    logic [1:0]       wn_reg;
    logic             ok_reg, ok_next;
    logic [2:0]       ackst_reg, ackst_next;
    logic             q_we;
    logic [TW-1:0]    q_wdata;
    // workers given a task by this item, and output register
    logic [WORKERS-1:0] dmask_reg, dmask_next;
    logic [WW-1:0]    pick;
    logic             out_free;
    logic             ovalid_reg, ovalid_next;
    logic             okind_reg, okind_next, ook_reg, ook_next, olast_reg, olast_next;
    logic             oidle_reg, oidle_next;
    logic [2:0]       ost_reg, ost_next;
    logic [3:0]       otask_reg, otask_next;
    logic [1:0]       owk_reg, owk_next;
    logic             ack_done_reg, ack_done_next;
    logic [2:0]       nact;
    logic             tvalid, pvalid;
    logic [TW-1:0]    t4, p4;

    assign tvalid = 32'(tid_reg) < TASKS;
    assign pvalid = 32'(pid_reg) < TASKS;
    assign t4 = TW'(tid_reg);
    assign p4 = TW'(pid_reg);
    always_comb
    begin
        if (act_reg == 3'd0)
            nact = dtd_pkg::ACT_ZERO_AS;
        else
            nact = act_reg;
        if (32'(nact) > WORKERS)
            nact = 3'(WORKERS);
    end

    // lowest worker still to report
    always_comb
    begin
        pick = '0;
        for (int w = WORKERS - 1; w >= 0; w--)
            if (dmask_reg[w])
                pick = WW'(w);
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (m_we_st)
            tst_mem[m_wa] <= m_wst;
        if (m_we_dep)
            dep_mem[m_wa] <= m_wdep;
        tst_q <= tst_mem[m_ra];
        dep_q <= dep_mem[m_ra];
        if (q_we)
            queue_mem[qt_reg] <= q_wdata;
        qrd_q <= queue_mem[qh_reg];
    end

    assign cfg_ready = (st_reg == S_IDLE);
    assign in_ready  = (st_reg == S_IDLE) && !cfg_valid;
    assign out_valid   = ovalid_reg;
    assign kind        = okind_reg;
    assign ok          = ook_reg;
    assign task_status = ost_reg;
    assign task_out    = otask_reg;
    assign worker_out  = owk_reg;
    assign last        = olast_reg;
    assign all_idle    = oidle_reg;
    assign out_free    = !ovalid_reg || out_ready;

    // sequencer
    always_comb
    begin
        st_next = st_reg; idx_next = idx_reg; wi_next = wi_reg;
        comp_next = comp_reg; wait_next = wait_reg;
        qh_next = qh_reg; qt_next = qt_reg; qc_next = qc_reg;
        wbusy_next = wbusy_reg; bc_next = bc_reg; fin_next = fin_reg;
        for (int w = 0; w < WORKERS; w++)
            wtask_next[w] = wtask_reg[w];
        ok_next = ok_reg; ackt_next = ackt_reg; ackst_next = ackst_reg;
        dmask_next = dmask_reg;
        ack_done_next = ack_done_reg;
        ovalid_next = ovalid_reg && !out_ready;
        okind_next = okind_reg; ook_next = ook_reg; olast_next = olast_reg;
        oidle_next = oidle_reg;
        ost_next = ost_reg; otask_next = otask_reg; owk_next = owk_reg;
        m_we_st = 1'b0; m_we_dep = 1'b0; m_wa = idx_reg; m_ra = idx_reg;
        m_wst = tst_q; m_wdep = dep_q;
        q_we = 1'b0; q_wdata = idx_reg;
        case (st_reg)
            S_CLR:
            begin
                m_we_st = 1'b1; m_we_dep = 1'b1;
                m_wst = dtd_pkg::ST_INIT; m_wdep = '0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == TLAST)
                    st_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    st_next = S_RD;
                end
            end
            S_RD:
            begin
                // worker done reads the finished task's entry
                if (rq_reg == dtd_pkg::REQ_DONE && 32'(wn_reg) < WORKERS
                    && wbusy_reg[WW'(wn_reg)])
                    m_ra = wtask_reg[WW'(wn_reg)];
                else
                    m_ra = t4;
                ackt_next = (rq_reg == dtd_pkg::REQ_DONE && 32'(wn_reg) < WORKERS
                    && wbusy_reg[WW'(wn_reg)]) ? 4'(wtask_reg[WW'(wn_reg)]) : tid_reg;
                st_next = S_EXEC;
            end
            S_EXEC:
            begin
                ok_next = 1'b0;
                ackst_next = tvalid ? tst_q : dtd_pkg::ST_INIT;
                m_wa = t4;
                case (rq_reg)
                    dtd_pkg::REQ_ADD:
                        if (tvalid && pvalid && tst_q == dtd_pkg::ST_INIT
                            && !dep_q[p4])
                        begin
                            m_we_dep = 1'b1;
                            m_wdep = dep_q | (TASKS'(1) << p4);
                            ok_next = 1'b1;
                        end
                    dtd_pkg::REQ_REM:
                        if (tvalid && pvalid && (tst_q == dtd_pkg::ST_INIT
                            || tst_q == dtd_pkg::ST_COMPLETE) && dep_q[p4])
                        begin
                            m_we_dep = 1'b1;
                            m_wdep = dep_q & ~(TASKS'(1) << p4);
                            ok_next = 1'b1;
                        end
                    dtd_pkg::REQ_SUB:
                        if (tvalid && (tst_q == dtd_pkg::ST_INIT
                            || tst_q == dtd_pkg::ST_COMPLETE))
                        begin
                            m_we_st = 1'b1;
                            ok_next = 1'b1;
                            comp_next[t4] = 1'b0;
                            if ((dep_q & ~comp_reg) == '0)
                            begin
                                m_wst = dtd_pkg::ST_QUEUED;
                                ackst_next = dtd_pkg::ST_QUEUED;
                                q_we = 1'b1; q_wdata = t4;
                                qt_next = qt_reg + 1'b1;
                                qc_next = qc_reg + 1'b1;
                            end
                            else
                            begin
                                m_wst = dtd_pkg::ST_WAITING;
                                ackst_next = dtd_pkg::ST_WAITING;
                                wait_next[t4] = 1'b1;
                            end
                        end
                    dtd_pkg::REQ_DONE:
                        if (32'(wn_reg) < WORKERS && wbusy_reg[WW'(wn_reg)])
                        begin
                            m_wa = TW'(ackt_reg);
                            m_we_st = 1'b1; m_wst = dtd_pkg::ST_COMPLETE;
                            ackst_next = dtd_pkg::ST_COMPLETE;
                            comp_next[TW'(ackt_reg)] = 1'b1;
                            wbusy_next[WW'(wn_reg)] = 1'b0;
                            if (bc_reg != '0)
                                bc_next = bc_reg - 1'b1;
                            fin_next = 1'b1;
                            ok_next = 1'b1;
                        end
                    dtd_pkg::REQ_QUERY:
                        ok_next = tvalid;
                    default: ;
                endcase
                idx_next = '0; wi_next = '0; ack_done_next = 1'b0;
                dmask_next = '0;
                st_next = (fin_next) ? S_SCANR : S_DISP;
            end
            S_SCANR:
            begin
                // rescan in index order; read entry idx
                m_ra = idx_reg;
                fin_next = 1'b0;
                st_next = wait_reg[idx_reg] ? S_DEPR : S_SCANW;
            end
            S_DEPR:
            begin
                m_wa = idx_reg;
                if ((dep_q & ~comp_reg) == '0)
                begin
                    m_we_st = 1'b1; m_wst = dtd_pkg::ST_QUEUED;
                    wait_next[idx_reg] = 1'b0;
                    q_we = 1'b1; q_wdata = idx_reg;
                    qt_next = qt_reg + 1'b1;
                    qc_next = qc_reg + 1'b1;
                    if (32'(idx_reg) == 32'(ackt_reg))
                        ackst_next = dtd_pkg::ST_QUEUED;
                end
                st_next = S_DEPW;
            end
            S_DEPW, S_SCANW:
            begin
                idx_next = idx_reg + 1'b1;
                st_next = (idx_reg == TLAST) ? S_DISP : S_SCANR;
            end
            S_DISP:
            begin
                // one worker per visit; the queue head is read this cycle
                if (32'(wi_reg) < 32'(nact) && qc_reg != '0)
                begin
                    if (wbusy_reg[wi_reg[WW-1:0]])
                        wi_next = wi_reg + 1'b1;
                    else
                        st_next = S_DISPW;
                end
                else
                    st_next = S_ACK;
            end
            S_DISPW:
            begin
                m_wa = qrd_q; m_we_st = 1'b1; m_wst = dtd_pkg::ST_WORKING;
                wbusy_next[wi_reg[WW-1:0]] = 1'b1;
                wtask_next[wi_reg[WW-1:0]] = qrd_q;
                dmask_next[wi_reg[WW-1:0]] = 1'b1;
                bc_next = bc_reg + 1'b1;
                qh_next = qh_reg + 1'b1;
                qc_next = qc_reg - 1'b1;
                if (32'(qrd_q) == 32'(ackt_reg))
                    ackst_next = dtd_pkg::ST_WORKING;
                wi_next = wi_reg + 1'b1;
                st_next = S_DISP;
            end
            S_ACK:
            begin
                // acknowledge first, then the dispatches in worker order
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oidle_next = (qc_reg == '0) && (wait_reg == '0) && (bc_reg == '0);
                    if (!ack_done_reg)
                    begin
                        okind_next = dtd_pkg::KIND_ACK;
                        ook_next = ok_reg; ost_next = ackst_reg;
                        otask_next = ackt_reg; owk_next = '0;
                        ack_done_next = 1'b1;
                        olast_next = (dmask_reg == '0);
                    end
                    else
                    begin
                        okind_next = dtd_pkg::KIND_DISP;
                        ook_next = 1'b1; ost_next = dtd_pkg::ST_WORKING;
                        otask_next = 4'(wtask_reg[pick]); owk_next = 2'(pick);
                        dmask_next[pick] = 1'b0;
                        olast_next = ((dmask_reg & ~(WORKERS'(1) << pick)) == '0);
                    end
                    if (olast_next)
                        st_next = S_IDLE;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLR; idx_reg <= '0; wi_reg <= '0;
            comp_reg <= '0; wait_reg <= '0;
            qh_reg <= '0; qt_reg <= '0; qc_reg <= '0;
            wbusy_reg <= '0; bc_reg <= '0; fin_reg <= 1'b0;
            act_reg <= dtd_pkg::ACT_DEF;
            dmask_reg <= '0; ovalid_reg <= 1'b0; ack_done_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; idx_reg <= idx_next; wi_reg <= wi_next;
            comp_reg <= comp_next; wait_reg <= wait_next;
            qh_reg <= qh_next; qt_reg <= qt_next; qc_reg <= qc_next;
            wbusy_reg <= wbusy_next; bc_reg <= bc_next; fin_reg <= fin_next;
            dmask_reg <= dmask_next; ovalid_reg <= ovalid_next;
            ack_done_reg <= ack_done_next;
            if (cfg_valid && cfg_ready)
                act_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rq_reg <= req_type; tid_reg <= task_id;
            pid_reg <= prereq_id; wn_reg <= worker_num;
        end
        ok_reg <= ok_next; ackt_reg <= ackt_next; ackst_reg <= ackst_next;
        okind_reg <= okind_next; ook_reg <= ook_next; olast_reg <= olast_next;
        oidle_reg <= oidle_next;
        ost_reg <= ost_next; otask_reg <= otask_next; owk_reg <= owk_next;
        for (int w = 0; w < WORKERS; w++)
            wtask_reg[w] <= wtask_next[w];
    end

    `DTD_ASSERT_IMP(a_in_idle, clk, rst_n, in_valid && in_ready, st_reg == S_IDLE)
    `DTD_ASSERT_IMP(a_qc_range, clk, rst_n, 1'b1, 32'(qc_reg) <= TASKS)
    `DTD_ASSERT_IMP(a_busy_cnt, clk, rst_n, 1'b1, 32'(bc_reg) == 32'($countones(wbusy_reg)))
    `DTD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(task_out))
endmodule
`default_nettype wire
